// ===== rtl/core/mbpd_pkg.sv =====
// Shared types and constants for the multi-button popcount debouncer.
// No dependencies; used by mbpd_lane and the top level.
package mbpd_pkg;

   localparam int KEY_BITS      = 4;   // width of the raw key and output masks
   localparam int TIME_W        = 32;  // millisecond timestamp width
   localparam int THR_W         = 4;   // threshold register width
   localparam int TIMEOUT_W     = 8;   // sleep timeout register width
   localparam int CNT_W         = 6;   // popcount compare width, holds up to 63
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 8;

   localparam logic [TIME_W-1:0] TIMEOUT_UNIT_MS = 32'd15000;
   localparam logic [31:0]       WAKE_HISTORY    = 32'd4;

   localparam logic [THR_W-1:0]  PRESS_THR_RESET   = 4'd4;
   localparam logic [THR_W-1:0]  RELEASE_THR_RESET = 4'd4;

   typedef enum logic {
      OP_TICK = 1'b0,
      OP_WAKE = 1'b1
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PRESS_THR   = 2'd0,
      CSR_RELEASE_THR = 2'd1,
      CSR_SLEEP_TMO   = 2'd2
   } csr_index_type;

   // settings shared by every button lane
   typedef struct packed {
      logic [THR_W-1:0]  press_thr;
      logic [THR_W-1:0]  release_thr;
      logic [TIME_W-1:0] window;      // sleep_timeout * 15000 ms
   } cfg_type;

   // per-item result of one lane
   typedef struct packed {
      logic pulse;
      logic held;
      logic in_window;
   } lane_out_type;

endpackage

// ===== rtl/core/mbpd_lane.sv =====
// One button lane: shift history, popcount thresholds, latch/fire flags, press stamp.
// Depends on mbpd_pkg.
module mbpd_lane #(
   parameter int HISTORY_BITS = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  mbpd_pkg::op_type            op,
   input  logic                        key_down,
   input  logic [mbpd_pkg::TIME_W-1:0] now_ms,
   input  mbpd_pkg::cfg_type           cfg,
   output mbpd_pkg::lane_out_type      lane_out
);

   logic [HISTORY_BITS-1:0]     hist_ff, hist_in;
   logic                        latched_ff, latched_in;
   logic                        fired_ff, fired_in;
   logic [mbpd_pkg::TIME_W-1:0] stamp_ff, stamp_in;

   logic [HISTORY_BITS-1:0]     hist_sh;
   logic [mbpd_pkg::CNT_W-1:0]  ones;
   logic [mbpd_pkg::TIME_W-1:0] age;
   logic                        pulse;

   assign hist_sh = {hist_ff[HISTORY_BITS-2:0], key_down};

   always_comb begin
      ones = '0;
      for (int b = 0; b < HISTORY_BITS; b++) begin
         ones = ones + mbpd_pkg::CNT_W'(hist_sh[b]);
      end
   end

   always_comb begin
      hist_in    = hist_sh;
      latched_in = latched_ff;
      fired_in   = fired_ff;
      stamp_in   = stamp_ff;
      pulse      = 1'b0;
      case (op)
         mbpd_pkg::OP_WAKE: begin
            hist_in    = HISTORY_BITS'(mbpd_pkg::WAKE_HISTORY);
            latched_in = 1'b1;
            fired_in   = 1'b1;
            stamp_in   = now_ms;
         end
         mbpd_pkg::OP_TICK: begin
            if (key_down) begin
               if (ones >= mbpd_pkg::CNT_W'(cfg.press_thr)) begin
                  if (!latched_ff) begin
                     latched_in = 1'b1;
                     stamp_in   = now_ms;
                  end
                  if (!fired_ff) begin
                     fired_in = 1'b1;
                     pulse    = 1'b1;
                  end
               end
            end else if (ones <= mbpd_pkg::CNT_W'(cfg.release_thr)) begin
               latched_in = 1'b0;
               fired_in   = 1'b0;
            end
         end
         default: begin
            hist_in = hist_sh;
         end
      endcase
   end

   // wrapping age of the (updated) press stamp
   assign age = now_ms - stamp_in;

   assign lane_out.pulse     = pulse;
   assign lane_out.held      = latched_in;
   assign lane_out.in_window = (age < cfg.window);

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff    <= '0;
         latched_ff <= 1'b0;
         fired_ff   <= 1'b0;
         stamp_ff   <= '0;
      end else if (advance) begin
         hist_ff    <= hist_in;
         latched_ff <= latched_in;
         fired_ff   <= fired_in;
         stamp_ff   <= stamp_in;
      end
   end

endmodule

// ===== rtl/core/multi_button_popcount_debouncer.sv =====
// Top level of the multi-button popcount debouncer: request register, settings,
// button lanes and the response register. Depends on mbpd_pkg and mbpd_lane.
// Usage:
//  - req channel: one request per 10 ms sample tick (req_tuser = OP_TICK, raw
//    active-low keys and millisecond time in req_tdata) or a wake command
//    (req_tuser = OP_WAKE, keys ignored).
//  - rsp channel: exactly one response per request, in order: press pulses,
//    held flags and the activity flag, all taken after the state update.
//  - csr port: csr_we/csr_index/csr_wdata write press threshold (0), release
//    threshold (1), sleep timeout (2); other indexes are ignored. Write only
//    while the block is idle. The timeout is turned into a millisecond window
//    at write time, so the request path carries no multiplier.
//  - Path: request register, then the button lanes, then response register.
//  - Throughput: one request per cycle while rsp_tready stays high; the lane
//    update (8-bit popcount compare plus a 32-bit wrapping age compare) fits
//    between the request register and the response register.
//  - Stall: while rsp_tready is low with a response pending, one more request
//    is held in the request register; then req_tready drops.
//  - Reset (synchronous): histories, flags and stamps clear, thresholds go to
//    4, timeout to 0 (always active); both channels empty.
module multi_button_popcount_debouncer #(
   parameter int NUM_BUTTONS  = 4,
   parameter int HISTORY_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request: tuser = opcode
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic                              req_tuser,   // [0] opcode
   input  logic [39:0]                       req_tdata,   // [3:0] raw_keys, [35:4] now_ms
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [15:0]                       rsp_tdata,   // [3:0] press_pulse, [7:4] held,
                                                          // [8] active
   // settings write port
   input  logic                              csr_we,
   input  logic [mbpd_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mbpd_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int KB    = mbpd_pkg::KEY_BITS;
   localparam int EXT_W = (NUM_BUTTONS > KB) ? NUM_BUTTONS : KB;

   // ---------------- settings ----------------
   logic [mbpd_pkg::THR_W-1:0]  press_thr_ff, press_thr_in;
   logic [mbpd_pkg::THR_W-1:0]  release_thr_ff, release_thr_in;
   logic [mbpd_pkg::TIME_W-1:0] window_ff, window_in;
   mbpd_pkg::cfg_type           cfg;

   always_comb begin
      press_thr_in   = press_thr_ff;
      release_thr_in = release_thr_ff;
      window_in      = window_ff;
      if (csr_we) begin
         case (csr_index)
            mbpd_pkg::CSR_PRESS_THR:   press_thr_in   = csr_wdata[mbpd_pkg::THR_W-1:0];
            mbpd_pkg::CSR_RELEASE_THR: release_thr_in = csr_wdata[mbpd_pkg::THR_W-1:0];
            mbpd_pkg::CSR_SLEEP_TMO: begin
               window_in = mbpd_pkg::TIME_W'(csr_wdata[mbpd_pkg::TIMEOUT_W-1:0])
                           * mbpd_pkg::TIMEOUT_UNIT_MS;
            end
            default: press_thr_in = press_thr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_thr_ff   <= mbpd_pkg::PRESS_THR_RESET;
         release_thr_ff <= mbpd_pkg::RELEASE_THR_RESET;
         window_ff      <= '0;
      end else begin
         press_thr_ff   <= press_thr_in;
         release_thr_ff <= release_thr_in;
         window_ff      <= window_in;
      end
   end

   assign cfg.press_thr   = press_thr_ff;
   assign cfg.release_thr = release_thr_ff;
   assign cfg.window      = window_ff;

   // ---------------- request register ----------------
   logic                        s1_valid_ff, s1_valid_in;
   mbpd_pkg::op_type            s1_op_ff;
   logic [KB-1:0]               s1_keys_ff;
   logic [mbpd_pkg::TIME_W-1:0] s1_now_ff;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        req_take;
   logic                        advance;

   // the lanes update when the request register holds a request and the
   // response register is free (or being emptied this cycle)
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff   <= mbpd_pkg::op_type'(req_tuser);
         s1_keys_ff <= req_tdata[KB-1:0];
         s1_now_ff  <= req_tdata[KB +: mbpd_pkg::TIME_W];
      end
   end

   // buttons beyond the key field read as released
   logic [EXT_W-1:0]       keys_ext;
   logic [NUM_BUTTONS-1:0] key_down;

   always_comb begin
      keys_ext         = '1;
      keys_ext[KB-1:0] = s1_keys_ff;
   end
   assign key_down = ~keys_ext[NUM_BUTTONS-1:0];

   // ---------------- button lanes ----------------
   mbpd_pkg::lane_out_type lane_out [NUM_BUTTONS];

   for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
      mbpd_lane #(
         .HISTORY_BITS(HISTORY_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .op       (s1_op_ff),
         .key_down (key_down[g]),
         .now_ms   (s1_now_ff),
         .cfg      (cfg),
         .lane_out (lane_out[g])
      );
   end

   // gather lane results; timeout zero means always active
   logic [EXT_W-1:0] pulse_ext;
   logic [EXT_W-1:0] held_ext;
   logic             active;

   always_comb begin
      pulse_ext = '0;
      held_ext  = '0;
      active    = (window_ff == '0);
      for (int i = 0; i < NUM_BUTTONS; i++) begin
         pulse_ext[i] = lane_out[i].pulse;
         held_ext[i]  = lane_out[i].held;
         active       = active | lane_out[i].in_window;
      end
   end

   // ---------------- response register ----------------
   logic [KB-1:0] rsp_pulse_ff;
   logic [KB-1:0] rsp_held_ff;
   logic          rsp_active_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_pulse_ff  <= pulse_ext[KB-1:0];
         rsp_held_ff   <= held_ext[KB-1:0];
         rsp_active_ff <= active;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_active_ff, rsp_held_ff, rsp_pulse_ff};

   // ---------------- assertions ----------------
   // a press pulse always comes with the held flag of the same button
   a_pulse_implies_held: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_pulse_ff & ~rsp_held_ff) == '0))
      else $error("press pulse without held flag");

   // a wake command never fires a press pulse
   a_wake_no_pulse: assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_op_ff == mbpd_pkg::OP_WAKE)) |=> (rsp_tvalid && (rsp_pulse_ff == '0)))
      else $error("press pulse on wake command");

   // back-pressure only when both the request and response registers are full
   a_ready_low_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("request stalled with a free stage");

   // each lane update produces a response in the next cycle
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("lane update lost its response");

endmodule
